/* rtl/core/srpg_pkg.sv */
package srpg_pkg;

  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = 40;
  localparam int DELAY_W  = 20;
  localparam int MIN_W    = 16;
  localparam int RAMP_W   = 16;
  localparam int FACTOR_W = 9;
  localparam int SPAN_W   = 20;
  localparam int DIV_STEPS = SPAN_W;

  localparam logic [IDX_W-1:0]   TOTAL_MAX = {IDX_W{1'b1}};
  localparam logic [DELAY_W-1:0] DELAY_MAX = {DELAY_W{1'b1}};

  localparam logic [MIN_W-1:0]    MIN_DELAY_RST = 16'd100;
  localparam logic [DELAY_W-1:0]  MAX_DELAY_RST = 20'd2500;
  localparam logic [RAMP_W-1:0]   RAMP_RST      = 16'd50;
  localparam logic [FACTOR_W-1:0] FACTOR_RST    = 9'd1;

  localparam logic [1:0] FUNC_TICK = 2'd0;
  localparam logic [1:0] FUNC_MOVE = 2'd1;
  localparam logic [1:0] FUNC_HOME = 2'd2;
  localparam logic [1:0] FUNC_STOP = 2'd3;

  localparam logic [1:0] REG_MIN_DELAY = 2'd0;
  localparam logic [1:0] REG_MAX_DELAY = 2'd1;
  localparam logic [1:0] REG_RAMP      = 2'd2;
  localparam logic [1:0] REG_FACTOR    = 2'd3;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic               step_level;
    logic               dir_level;
    logic               busy_res;
    logic signed [31:0] position;
    logic               dropped;
  } out_item_t;

  function automatic logic [DELAY_W-1:0] clamp_delay(input logic [DELAY_W+1:0] d);
    if (d[DELAY_W+1] || d == '0) begin
      return DELAY_W'(1);
    end
    if (d[DELAY_W]) begin
      return DELAY_MAX;
    end
    return d[DELAY_W-1:0];
  endfunction

endpackage

/* rtl/core/stepper_ramp_pulse_generator_core.sv */
// A move, set home or stop item goes straight to its result; a tick at a pulse boundary
// takes the minimum delay in cruise, or on a ramp runs a 16-step shift-add and a 20-step
// restoring divide; a tick that starts a move runs a 9-step shift-add first.
// One item is in work at a time; the next transaction is taken once the result is registered.
// Reset is asynchronous, active low: control state and position clear, configuration
// registers take their reset values; the move queue storage is not cleared and needs no clearing pass.
module stepper_ramp_pulse_generator_core #(
  parameter int QUEUE_DEPTH = 4,
  parameter int POS_WIDTH   = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  srpg_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output srpg_pkg::out_item_t             out_data_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [srpg_pkg::ADDR_W-1:0]     paddr,
  input  logic [srpg_pkg::DATA_W-1:0]     pwdata,
  output logic [srpg_pkg::DATA_W-1:0]     prdata,
  output logic                            pready
);
  import srpg_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int MUL_W = (POS_WIDTH + FACTOR_W > IDX_W + 1) ? POS_WIDTH + FACTOR_W : IDX_W + 1;
  localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TICK  = 4'd1;
  localparam logic [3:0] S_POP   = 4'd2;
  localparam logic [3:0] S_MULN  = 4'd3;
  localparam logic [3:0] S_BOUND = 4'd4;
  localparam logic [3:0] S_MULR  = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_DONE  = 4'd7;

  logic [3:0]           state_q;
  logic [MIN_W-1:0]     min_delay_q;
  logic [DELAY_W-1:0]   max_delay_q;
  logic [RAMP_W-1:0]    ramp_q;
  logic [FACTOR_W-1:0]  factor_q;

  logic [POS_WIDTH-1:0] cur_pos_q;
  logic [POS_WIDTH-1:0] goal_pos_q;
  logic                 stop_q;
  logic                 moving_q;
  logic                 step_q;
  logic                 dir_q;
  logic [IDX_W-1:0]     pulse_index_q;
  logic [IDX_W-1:0]     pulse_total_q;
  logic [DELAY_W-1:0]   half_timer_q;
  logic [DELAY_W-1:0]   half_delay_q;
  logic                 drop_q;

  logic [POS_WIDTH-1:0] fifo_mem_q [QUEUE_DEPTH];
  logic [POS_WIDTH-1:0] rd_data_q;
  logic [PTR_W-1:0]     rd_ptr_q;
  logic [PTR_W-1:0]     wr_ptr_q;
  logic [CNT_W-1:0]     fifo_cnt_q;

  logic [MUL_W-1:0]     acc_q;
  logic [MUL_W-1:0]     mcand_q;
  logic [RAMP_W-1:0]    mplr_q;
  logic [4:0]           cnt_q;
  logic [RAMP_W-1:0]    rem_q;
  logic [SPAN_W-1:0]    dq_q;
  logic                 neg_q;

  logic                 out_valid_q;
  out_item_t            out_q;

  logic                 accept_in;
  logic                 cfg_write;
  logic                 out_load;
  logic [63:0]          vext;
  logic [POS_WIDTH-1:0] value_pos;
  logic                 fifo_full;
  logic                 mem_we;
  logic [PTR_W-1:0]     rd_ptr_nxt;
  logic [PTR_W-1:0]     wr_ptr_nxt;
  logic [DELAY_W-1:0]   timer_dec;
  logic [POS_WIDTH-1:0] diff;
  logic                 diff_neg;
  logic [POS_WIDTH-1:0] mag;
  logic [MUL_W-1:0]     mul_add;
  logic [IDX_W-1:0]     total_sat;
  logic [IDX_W-1:0]     ramp_ext;
  logic                 idx_lt;
  logic [IDX_W-1:0]     remain;
  logic                 rem_lt;
  logic                 move_end;
  logic [SPAN_W:0]      span_w;
  logic [SPAN_W-1:0]    span_mag;
  logic [DELAY_W-1:0]   min_clamped;
  logic [RAMP_W-1:0]    ramp_t;
  logic [RAMP_W:0]      div_r2;
  logic                 div_ge;
  logic [RAMP_W:0]      div_sub;
  logic [DELAY_W+1:0]   ramp_sum;
  logic [63:0]          pos_wide;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept_in   = in_valid_i & in_ready_o;
  assign cfg_write   = psel & penable & pwrite;
  assign pready      = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_load    = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  assign vext      = {{32{in_data_i.value[31]}}, in_data_i.value};
  assign value_pos = vext[POS_WIDTH-1:0];
  assign fifo_full = (fifo_cnt_q == DEPTH_CNT);
  assign mem_we    = accept_in && (in_data_i.func == FUNC_MOVE) && !fifo_full;
  assign rd_ptr_nxt = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
  assign wr_ptr_nxt = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);

  assign timer_dec = half_timer_q - DELAY_W'(half_timer_q != '0);
  assign diff      = rd_data_q - cur_pos_q;
  assign diff_neg  = diff[POS_WIDTH-1];
  assign mag       = diff_neg ? (~diff + POS_WIDTH'(1)) : diff;

  assign mul_add   = acc_q + (mplr_q[0] ? mcand_q : '0);
  assign total_sat = (|acc_q[MUL_W-1:IDX_W]) ? TOTAL_MAX : acc_q[IDX_W-1:0];

  assign ramp_ext  = IDX_W'(ramp_q);
  assign idx_lt    = pulse_index_q < ramp_ext;
  assign remain    = pulse_total_q - pulse_index_q;
  assign rem_lt    = remain < ramp_ext;
  assign move_end  = stop_q || (pulse_index_q >= pulse_total_q);
  assign span_w    = {1'b0, max_delay_q} - (SPAN_W + 1)'(min_delay_q);
  assign span_mag  = span_w[SPAN_W] ? SPAN_W'(~span_w + (SPAN_W + 1)'(1)) : span_w[SPAN_W-1:0];
  assign min_clamped = (min_delay_q == '0) ? DELAY_W'(1) : DELAY_W'(min_delay_q);
  assign ramp_t    = idx_lt ? pulse_index_q[RAMP_W-1:0] : remain[RAMP_W-1:0];

  assign div_r2    = {rem_q, dq_q[SPAN_W-1]};
  assign div_ge    = div_r2 >= {1'b0, ramp_q};
  assign div_sub   = div_r2 - {1'b0, ramp_q};
  assign ramp_sum  = neg_q ? ({2'b00, max_delay_q} + (DELAY_W + 2)'(dq_q))
                           : ({2'b00, max_delay_q} - (DELAY_W + 2)'(dq_q));
  assign pos_wide  = 64'(cur_pos_q);

  always_comb begin
    unique case (paddr[3:2])
      REG_MIN_DELAY: prdata = DATA_W'(min_delay_q);
      REG_MAX_DELAY: prdata = DATA_W'(max_delay_q);
      REG_RAMP:      prdata = DATA_W'(ramp_q);
      REG_FACTOR:    prdata = DATA_W'(factor_q);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      fifo_mem_q[wr_ptr_q] <= value_pos;
    end
    if (state_q == S_TICK) begin
      rd_data_q <= fifo_mem_q[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      min_delay_q   <= MIN_DELAY_RST;
      max_delay_q   <= MAX_DELAY_RST;
      ramp_q        <= RAMP_RST;
      factor_q      <= FACTOR_RST;
      cur_pos_q     <= '0;
      goal_pos_q    <= '0;
      stop_q        <= 1'b0;
      moving_q      <= 1'b0;
      step_q        <= 1'b0;
      dir_q         <= 1'b0;
      pulse_index_q <= '0;
      pulse_total_q <= '0;
      half_timer_q  <= '0;
      half_delay_q  <= '0;
      drop_q        <= 1'b0;
      rd_ptr_q      <= '0;
      wr_ptr_q      <= '0;
      fifo_cnt_q    <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (paddr[3:2])
          REG_MIN_DELAY: min_delay_q <= pwdata[MIN_W-1:0];
          REG_MAX_DELAY: max_delay_q <= pwdata[DELAY_W-1:0];
          REG_RAMP:      ramp_q      <= pwdata[RAMP_W-1:0];
          REG_FACTOR:    factor_q    <= pwdata[FACTOR_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept_in) begin
            drop_q  <= (in_data_i.func == FUNC_MOVE) && fifo_full;
            state_q <= (in_data_i.func == FUNC_TICK) ? S_TICK : S_DONE;
            unique case (in_data_i.func)
              FUNC_TICK: ;
              FUNC_MOVE: begin
                if (!fifo_full) begin
                  wr_ptr_q   <= wr_ptr_nxt;
                  fifo_cnt_q <= fifo_cnt_q + CNT_W'(1);
                end
              end
              FUNC_HOME: cur_pos_q <= value_pos;
              FUNC_STOP: stop_q <= 1'b1;
              default: ;
            endcase
          end
        end
        S_TICK: begin
          if (!moving_q) begin
            state_q <= (fifo_cnt_q != '0) ? S_POP : S_DONE;
          end else if (timer_dec != '0) begin
            half_timer_q <= timer_dec;
            state_q      <= S_DONE;
          end else if (step_q) begin
            step_q       <= 1'b0;
            half_timer_q <= half_delay_q;
            state_q      <= S_DONE;
          end else begin
            half_timer_q <= '0;
            cur_pos_q    <= dir_q ? cur_pos_q + POS_WIDTH'(1) : cur_pos_q - POS_WIDTH'(1);
            if (pulse_index_q != TOTAL_MAX) begin
              pulse_index_q <= pulse_index_q + IDX_W'(1);
            end
            state_q <= S_BOUND;
          end
        end
        S_POP: begin
          goal_pos_q <= rd_data_q;
          dir_q      <= !diff_neg && (diff != '0);
          rd_ptr_q   <= rd_ptr_nxt;
          fifo_cnt_q <= fifo_cnt_q - CNT_W'(1);
          state_q    <= S_MULN;
        end
        S_MULN: begin
          if (cnt_q == '0) begin
            pulse_total_q <= total_sat;
            pulse_index_q <= '0;
            moving_q      <= 1'b1;
            state_q       <= S_BOUND;
          end
        end
        S_BOUND: begin
          if (move_end) begin
            moving_q     <= 1'b0;
            step_q       <= 1'b0;
            stop_q       <= 1'b0;
            goal_pos_q   <= cur_pos_q;
            half_timer_q <= '0;
            state_q      <= S_DONE;
          end else if (ramp_q == '0 || (!idx_lt && !rem_lt)) begin
            half_delay_q <= min_clamped;
            half_timer_q <= min_clamped;
            step_q       <= 1'b1;
            state_q      <= S_DONE;
          end else begin
            state_q <= S_MULR;
          end
        end
        S_MULR: begin
          if (cnt_q == '0) begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (cnt_q == '0) begin
            half_delay_q <= clamp_delay(ramp_sum);
            half_timer_q <= clamp_delay(ramp_sum);
            step_q       <= 1'b1;
            state_q      <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_POP: begin
        acc_q   <= '0;
        mcand_q <= MUL_W'(mag);
        mplr_q  <= RAMP_W'(factor_q);
        cnt_q   <= 5'(FACTOR_W);
      end
      S_BOUND: begin
        acc_q   <= '0;
        mcand_q <= MUL_W'(span_mag);
        mplr_q  <= ramp_t;
        neg_q   <= span_w[SPAN_W];
        cnt_q   <= 5'(RAMP_W);
      end
      S_MULN, S_MULR: begin
        if (cnt_q != '0) begin
          acc_q   <= mul_add;
          mcand_q <= {mcand_q[MUL_W-2:0], 1'b0};
          mplr_q  <= {1'b0, mplr_q[RAMP_W-1:1]};
          cnt_q   <= cnt_q - 5'd1;
        end else if (state_q == S_MULR) begin
          rem_q <= acc_q[SPAN_W+RAMP_W-1:SPAN_W];
          dq_q  <= acc_q[SPAN_W-1:0];
          cnt_q <= 5'(DIV_STEPS);
        end
      end
      S_DIV: begin
        if (cnt_q != '0) begin
          rem_q <= div_ge ? div_sub[RAMP_W-1:0] : div_r2[RAMP_W-1:0];
          dq_q  <= {dq_q[SPAN_W-2:0], div_ge};
          cnt_q <= cnt_q - 5'd1;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_q.step_level <= step_q;
      out_q.dir_level  <= dir_q;
      out_q.busy_res   <= !stop_q && (cur_pos_q != goal_pos_q);
      out_q.position   <= pos_wide[31:0];
      out_q.dropped    <= drop_q;
    end
  end

`ifndef NO_ASSERTIONS
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_cnt_q <= DEPTH_CNT)
    else $error("move queue count exceeds depth");

  a_step_needs_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !moving_q |-> !step_q)
    else $error("step high while no move runs");

  a_timer_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (moving_q && state_q == S_IDLE) |-> (half_timer_q != '0))
    else $error("half timer empty during a move");

  a_index_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (moving_q && state_q == S_IDLE) |-> (pulse_index_q < pulse_total_q))
    else $error("pulse index past total during a move");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < ramp_q))
    else $error("divider remainder out of range");
`endif

endmodule
